@@ sv/tpim_pkg.sv @@
// Package for the tau pair invariant mass block: codes, widths, constants.
// Used by tpim_ctrl, tpim_dp, tau_pair_invariant_mass and the testbench (no other dependencies).
`default_nettype none

package tpim_pkg;

  localparam int unsigned PtW       = 16;
  localparam int unsigned EtaW      = 14;
  localparam int unsigned PhiW      = 13;
  localparam int unsigned ChgW      = 2;
  localparam int unsigned LimW      = 13;
  localparam int unsigned CntW      = 8;
  localparam int unsigned MassW     = 20;
  localparam int unsigned Terms     = 24;
  localparam int unsigned KW        = 5;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CntW-1:0]  CountMax    = 8'd255;
  localparam logic [PtW-1:0]   PtMinRst    = 16'd320;
  localparam logic [LimW-1:0]  EtaLimRst   = 13'd2355;
  localparam logic [MassW-1:0] MassMax     = 20'hFFFFF;
  localparam logic [KW-1:0]    KLast       = 5'(Terms - 1);

  // register indexes
  localparam logic REG_PT_MIN    = 1'b0;
  localparam logic REG_ETA_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_SEL  = 2'd0,
    ST_FEW  = 2'd1,
    ST_SIGN = 2'd2,
    ST_CUT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MS_XX,
    MS_TX,
    MS_SH,
    MS_SN,
    MS_QP
  } mul_sel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_X_GO,
    S_X_WAIT,
    S_X2,
    S_T_GO,
    S_T_WAIT,
    S_D_GO,
    S_D_WAIT,
    S_ACC,
    S_FIN,
    S_Q1_GO,
    S_Q1_WAIT,
    S_Q2_GO,
    S_Q2_WAIT,
    S_P_GO,
    S_P_WAIT,
    S_R_GO,
    S_R_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic           take;
    logic           load_x;
    logic           mul_start;
    mul_sel_e       mul_sel;
    logic           mul_clr;
    logic           latch_x2;
    logic           div_start;
    logic [KW-1:0]  k;
    logic           acc_term;
    logic           fin;
    logic           hyp;
    logic           sqrt_start;
    logic           out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic need_mass;
    logic out_free;
  } stat_t;

  // Taylor term divisor (2k+2)(2k+3)
  function automatic logic [11:0] term_div(input logic [KW-1:0] k);
    logic [11:0] a;
    logic [11:0] b;
    begin
      a = {6'd0, k, 1'b0} + 12'd2;
      b = {6'd0, k, 1'b0} + 12'd3;
      term_div = a * b;
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/tpim_ctrl.sv @@
// Sequencer for the tau pair block: walks the series, squares, product and sqrt.
// Depends on tpim_pkg; drives tpim_dp through cmd_t and watches stat_t.
`default_nettype none

module tpim_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  tpim_pkg::stat_t stat_i,
  output tpim_pkg::cmd_t  cmd_o
);

  tpim_pkg::state_e            state_q, state_d;
  logic [tpim_pkg::KW-1:0]     k_q, k_d;
  logic                        hyp_q, hyp_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpim_pkg::S_IDLE;
      k_q     <= '0;
      hyp_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      hyp_q   <= hyp_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    hyp_d   = hyp_q;
    cmd_o   = '0;
    cmd_o.k   = k_q;
    cmd_o.hyp = hyp_q;
    cmd_o.mul_sel = tpim_pkg::MS_XX;
    unique case (state_q)
      tpim_pkg::S_IDLE: begin
        cmd_o.take = stat_i.out_free;
        if (stat_i.need_mass) begin
          hyp_d   = 1'b1;
          state_d = tpim_pkg::S_LOAD;
        end
      end
      tpim_pkg::S_LOAD: begin
        cmd_o.load_x = 1'b1;
        k_d     = '0;
        state_d = tpim_pkg::S_X_GO;
      end
      tpim_pkg::S_X_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_clr   = 1'b1;
        cmd_o.mul_sel   = tpim_pkg::MS_XX;
        state_d = tpim_pkg::S_X_WAIT;
      end
      tpim_pkg::S_X_WAIT: begin
        if (stat_i.mul_done) state_d = tpim_pkg::S_X2;
      end
      tpim_pkg::S_X2: begin
        cmd_o.latch_x2 = 1'b1;
        state_d = tpim_pkg::S_T_GO;
      end
      tpim_pkg::S_T_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_clr   = 1'b1;
        cmd_o.mul_sel   = tpim_pkg::MS_TX;
        state_d = tpim_pkg::S_T_WAIT;
      end
      tpim_pkg::S_T_WAIT: begin
        if (stat_i.mul_done) state_d = tpim_pkg::S_D_GO;
      end
      tpim_pkg::S_D_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = tpim_pkg::S_D_WAIT;
      end
      tpim_pkg::S_D_WAIT: begin
        if (stat_i.div_done) state_d = tpim_pkg::S_ACC;
      end
      tpim_pkg::S_ACC: begin
        cmd_o.acc_term = 1'b1;
        if (k_q == tpim_pkg::KLast) begin
          k_d     = '0;
          state_d = tpim_pkg::S_FIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = tpim_pkg::S_T_GO;
        end
      end
      tpim_pkg::S_FIN: begin
        cmd_o.fin = 1'b1;
        if (hyp_q) begin
          hyp_d   = 1'b0;
          state_d = tpim_pkg::S_LOAD;
        end else begin
          hyp_d   = 1'b1;
          state_d = tpim_pkg::S_Q1_GO;
        end
      end
      tpim_pkg::S_Q1_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_clr   = 1'b1;
        cmd_o.mul_sel   = tpim_pkg::MS_SH;
        state_d = tpim_pkg::S_Q1_WAIT;
      end
      tpim_pkg::S_Q1_WAIT: begin
        if (stat_i.mul_done) state_d = tpim_pkg::S_Q2_GO;
      end
      tpim_pkg::S_Q2_GO: begin
        // accumulate on top of sinh^2
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = tpim_pkg::MS_SN;
        state_d = tpim_pkg::S_Q2_WAIT;
      end
      tpim_pkg::S_Q2_WAIT: begin
        if (stat_i.mul_done) state_d = tpim_pkg::S_P_GO;
      end
      tpim_pkg::S_P_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_clr   = 1'b1;
        cmd_o.mul_sel   = tpim_pkg::MS_QP;
        state_d = tpim_pkg::S_P_WAIT;
      end
      tpim_pkg::S_P_WAIT: begin
        if (stat_i.mul_done) state_d = tpim_pkg::S_R_GO;
      end
      tpim_pkg::S_R_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = tpim_pkg::S_R_WAIT;
      end
      tpim_pkg::S_R_WAIT: begin
        if (stat_i.sqrt_done) state_d = tpim_pkg::S_OUT;
      end
      tpim_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = tpim_pkg::S_IDLE;
        end
      end
      default: state_d = tpim_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/tpim_dp.sv @@
// Datapath for the tau pair block: top-two tracking, selection, series,
// shared 32x32 multiplier, term divider, square root and output register.
// Depends on tpim_pkg; commanded by tpim_ctrl.
`default_nettype none

module tpim_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  tpim_pkg::cmd_t                   cmd_i,
  output tpim_pkg::stat_t                  stat_o,
  input  wire                              cfg_we_i,
  input  wire                              cfg_addr_i,
  input  wire [tpim_pkg::CfgW-1:0]         cfg_wdata_i,
  input  wire                              in_valid_i,
  input  wire                              in_tau_i,
  input  wire [tpim_pkg::PtW-1:0]          in_pt_i,
  input  wire signed [tpim_pkg::EtaW-1:0]  in_eta_i,
  input  wire signed [tpim_pkg::PhiW-1:0]  in_phi_i,
  input  wire signed [tpim_pkg::ChgW-1:0]  in_chg_i,
  input  wire                              in_last_i,
  input  wire                              out_ready_i,
  output logic                             out_valid_o,
  output logic [1:0]                       out_status_o,
  output logic [tpim_pkg::MassW-1:0]       out_mass_o,
  output logic [tpim_pkg::CntW-1:0]        out_count_o
);

  localparam logic signed [tpim_pkg::ChgW-1:0] ChgPos = 2'sb01;
  localparam logic signed [tpim_pkg::ChgW-1:0] ChgNeg = 2'sb11;

  // configuration
  logic [tpim_pkg::PtW-1:0]  pt_min_q;
  logic [tpim_pkg::LimW-1:0] eta_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_min_q  <= tpim_pkg::PtMinRst;
      eta_lim_q <= tpim_pkg::EtaLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tpim_pkg::REG_PT_MIN:    pt_min_q  <= cfg_wdata_i;
        tpim_pkg::REG_ETA_LIMIT: eta_lim_q <= cfg_wdata_i[tpim_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // event state
  logic [tpim_pkg::PtW-1:0]         lpt_q, lpt_d, spt_q, spt_d;
  logic signed [tpim_pkg::EtaW-1:0] leta_q, leta_d, seta_q, seta_d;
  logic signed [tpim_pkg::PhiW-1:0] lphi_q, lphi_d, sphi_q, sphi_d;
  logic signed [tpim_pkg::ChgW-1:0] lchg_q, lchg_d, schg_q, schg_d;
  logic [tpim_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic                             accept;

  assign accept = in_valid_i & cmd_i.take;

  // top-two update for this beat
  always_comb begin
    lpt_d = lpt_q;  leta_d = leta_q;  lphi_d = lphi_q;  lchg_d = lchg_q;
    spt_d = spt_q;  seta_d = seta_q;  sphi_d = sphi_q;  schg_d = schg_q;
    cnt_d = cnt_q;
    if (in_tau_i) begin
      priority if (cnt_q == '0) begin
        lpt_d = in_pt_i; leta_d = in_eta_i; lphi_d = in_phi_i; lchg_d = in_chg_i;
      end else if (in_pt_i > lpt_q) begin
        spt_d = lpt_q; seta_d = leta_q; sphi_d = lphi_q; schg_d = lchg_q;
        lpt_d = in_pt_i; leta_d = in_eta_i; lphi_d = in_phi_i; lchg_d = in_chg_i;
      end else if (cnt_q == 8'd1 || in_pt_i > spt_q) begin
        spt_d = in_pt_i; seta_d = in_eta_i; sphi_d = in_phi_i; schg_d = in_chg_i;
      end else begin
      end
      if (cnt_q < tpim_pkg::CountMax) cnt_d = cnt_q + 1'b1;
    end
  end

  // selection on the updated pair
  logic [tpim_pkg::EtaW-1:0] ae1, ae2;
  logic                      opp, kin_ok;
  tpim_pkg::status_e         st;

  assign ae1 = leta_d[tpim_pkg::EtaW-1] ? tpim_pkg::EtaW'(-leta_d) : leta_d;
  assign ae2 = seta_d[tpim_pkg::EtaW-1] ? tpim_pkg::EtaW'(-seta_d) : seta_d;
  assign opp = (lchg_d == ChgPos && schg_d == ChgNeg) ||
               (lchg_d == ChgNeg && schg_d == ChgPos);
  assign kin_ok = (lpt_d > pt_min_q) && (spt_d > pt_min_q) &&
                  (ae1 < {1'b0, eta_lim_q}) && (ae2 < {1'b0, eta_lim_q});

  always_comb begin
    priority if (cnt_d < 8'd2) st = tpim_pkg::ST_FEW;
    else if (!opp)             st = tpim_pkg::ST_SIGN;
    else if (!kin_ok)          st = tpim_pkg::ST_CUT;
    else                       st = tpim_pkg::ST_SEL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpt_q <= '0; leta_q <= '0; lphi_q <= '0; lchg_q <= '0;
      spt_q <= '0; seta_q <= '0; sphi_q <= '0; schg_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      if (in_last_i) begin
        lpt_q <= '0; leta_q <= '0; lphi_q <= '0; lchg_q <= '0;
        spt_q <= '0; seta_q <= '0; sphi_q <= '0; schg_q <= '0;
        cnt_q <= '0;
      end else begin
        lpt_q <= lpt_d; leta_q <= leta_d; lphi_q <= lphi_d; lchg_q <= lchg_d;
        spt_q <= spt_d; seta_q <= seta_d; sphi_q <= sphi_d; schg_q <= schg_d;
        cnt_q <= cnt_d;
      end
    end
  end

  // pair held for the mass computation
  logic                             need_mass;
  logic signed [tpim_pkg::EtaW-1:0] e1_q, e2_q;
  logic signed [tpim_pkg::PhiW-1:0] f1_q, f2_q;
  logic [tpim_pkg::PtW-1:0]         pt1_q, pt2_q;
  logic [31:0]                      p_q;
  logic [tpim_pkg::CntW-1:0]        pcnt_q;

  assign need_mass = accept & in_last_i & (st == tpim_pkg::ST_SEL);

  always_ff @(posedge clk_i) begin
    if (need_mass) begin
      e1_q <= leta_d; e2_q <= seta_d;
      f1_q <= lphi_d; f2_q <= sphi_d;
      pt1_q <= lpt_d; pt2_q <= spt_d;
      pcnt_q <= cnt_d;
    end
    p_q <= pt1_q * pt2_q;
  end

  // half-angle argument in Q32
  logic signed [tpim_pkg::EtaW:0] de;
  logic signed [tpim_pkg::PhiW:0] df;
  logic [tpim_pkg::EtaW:0]        ade;
  logic [tpim_pkg::PhiW:0]        adf;
  logic [63:0]                    xin;

  assign de  = (tpim_pkg::EtaW+1)'(e1_q) - (tpim_pkg::EtaW+1)'(e2_q);
  assign df  = (tpim_pkg::PhiW+1)'(f1_q) - (tpim_pkg::PhiW+1)'(f2_q);
  assign ade = de[tpim_pkg::EtaW] ? (tpim_pkg::EtaW+1)'(-de) : de;
  assign adf = df[tpim_pkg::PhiW] ? (tpim_pkg::PhiW+1)'(-df) : df;
  assign xin = cmd_i.hyp ? (64'(ade) << 21) : (64'(adf) << 21);

  // shared multiplier: 128 x 64 mod 2^128, one 32x32 partial per cycle
  logic [127:0] ma_q, acc_q;
  logic [63:0]  mb_q, prod_q;
  logic [2:0]   psh_q;
  logic         pv_q, mbusy_q;
  logic [3:0]   mcnt_q;
  logic [63:0]  x_q, x2_q, t_q, sum_q, sh_q, sn_q;
  logic [127:0] ma_sel;
  logic [63:0]  mb_sel;
  logic [127:0] pshift;

  always_comb begin
    unique case (cmd_i.mul_sel)
      tpim_pkg::MS_XX: begin ma_sel = {64'd0, x_q};  mb_sel = x_q;  end
      tpim_pkg::MS_TX: begin ma_sel = {64'd0, t_q};  mb_sel = x2_q; end
      tpim_pkg::MS_SH: begin ma_sel = {64'd0, sh_q}; mb_sel = sh_q; end
      tpim_pkg::MS_SN: begin ma_sel = {64'd0, sn_q}; mb_sel = sn_q; end
      tpim_pkg::MS_QP: begin ma_sel = acc_q;         mb_sel = {32'd0, p_q}; end
      default:         begin ma_sel = '0;            mb_sel = '0;   end
    endcase
  end

  assign pshift = {64'd0, prod_q} << {psh_q, 5'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      pv_q    <= 1'b0;
      mcnt_q  <= '0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
      pv_q    <= 1'b0;
      mcnt_q  <= '0;
    end else if (mbusy_q) begin
      if (mcnt_q == 4'd8) begin
        mbusy_q <= 1'b0;
        pv_q    <= 1'b0;
      end else begin
        pv_q   <= 1'b1;
        mcnt_q <= mcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      ma_q <= ma_sel;
      mb_q <= mb_sel;
      if (cmd_i.mul_clr) acc_q <= '0;
    end else if (mbusy_q) begin
      if (pv_q) acc_q <= acc_q + pshift;
      prod_q <= ma_q[{mcnt_q[1:0], 5'd0} +: 32] * mb_q[{mcnt_q[2], 5'd0} +: 32];
      psh_q  <= {1'b0, mcnt_q[1:0]} + {2'b0, mcnt_q[2]};
    end
  end

  // term divider: restoring, one quotient bit per cycle
  logic        dbusy_q;
  logic [5:0]  dcnt_q;
  logic [11:0] rem_q, dd_q;
  logic [12:0] dtrial;
  logic        dge;

  assign dtrial = {rem_q, t_q[63]};
  assign dge    = dtrial >= {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (dcnt_q == 6'd63) dbusy_q <= 1'b0;
    end
  end

  // series registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q   <= xin;
      t_q   <= xin;
      sum_q <= xin;
    end else if (cmd_i.div_start) begin
      t_q   <= acc_q[95:32];
      rem_q <= '0;
      dd_q  <= tpim_pkg::term_div(cmd_i.k);
    end else if (dbusy_q) begin
      t_q   <= {t_q[62:0], dge};
      rem_q <= dge ? 12'(dtrial - {1'b0, dd_q}) : dtrial[11:0];
    end
    if (cmd_i.latch_x2) x2_q <= acc_q[95:32];
    if (cmd_i.acc_term) begin
      // sin alternates starting with a subtraction
      if (!cmd_i.hyp && !cmd_i.k[0]) sum_q <= sum_q - t_q;
      else                           sum_q <= sum_q + t_q;
    end
    if (cmd_i.fin) begin
      if (cmd_i.hyp)       sh_q <= sum_q;
      else if (sum_q[63])  sn_q <= -sum_q;
      else                 sn_q <= sum_q;
    end
  end

  // integer square root, two bits of the radicand per cycle
  logic        sbusy_q, sat_q;
  logic [4:0]  scnt_q;
  logic [63:0] sv_q, sr_q, sbit, strial;

  assign sbit   = 64'd1 << (7'd62 - {1'b0, scnt_q, 1'b0});
  assign strial = sr_q + sbit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      scnt_q  <= '0;
    end else if (cmd_i.sqrt_start) begin
      sbusy_q <= 1'b1;
      scnt_q  <= '0;
    end else if (sbusy_q) begin
      scnt_q <= scnt_q + 1'b1;
      if (scnt_q == 5'd31) sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sv_q  <= acc_q[103:40];
      sr_q  <= '0;
      sat_q <= |acc_q[127:102];
    end else if (sbusy_q) begin
      if (sv_q >= strial) begin
        sv_q <= sv_q - strial;
        sr_q <= (sr_q >> 1) + sbit;
      end else begin
        sr_q <= sr_q >> 1;
      end
    end
  end

  // rounding and saturation of the mass
  logic [32:0]                 rr;
  logic [tpim_pkg::MassW-1:0]  mass;

  assign rr   = sr_q[32:0] + 33'd1024;
  assign mass = (sat_q || |rr[32:31]) ? tpim_pkg::MassMax : rr[30:11];

  // output register
  logic                       mv_q, out_free;
  logic [1:0]                 mst_q;
  logic [tpim_pkg::MassW-1:0] mmass_q;
  logic [tpim_pkg::CntW-1:0]  mcnt_out_q;
  logic                       direct_load;

  assign out_free    = !mv_q || out_ready_i;
  assign direct_load = accept & in_last_i & (st != tpim_pkg::ST_SEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (direct_load || cmd_i.out_load) begin
      mv_q <= 1'b1;
    end else if (out_ready_i) begin
      mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (direct_load) begin
      mst_q      <= st;
      mmass_q    <= '0;
      mcnt_out_q <= cnt_d;
    end else if (cmd_i.out_load) begin
      mst_q      <= tpim_pkg::ST_SEL;
      mmass_q    <= mass;
      mcnt_out_q <= pcnt_q;
    end
  end

  assign out_valid_o  = mv_q;
  assign out_status_o = mst_q;
  assign out_mass_o   = mmass_q;
  assign out_count_o  = mcnt_out_q;

  assign stat_o.mul_done  = mbusy_q && (mcnt_q == 4'd8);
  assign stat_o.div_done  = dbusy_q && (dcnt_q == 6'd63);
  assign stat_o.sqrt_done = sbusy_q && (scnt_q == 5'd31);
  assign stat_o.need_mass = need_mass;
  assign stat_o.out_free  = out_free;

  // units never run at the same time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({mbusy_q, dbusy_q, sbusy_q}) <= 1)
    else $error("arithmetic units overlap");

  // a rejected event carries no mass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q && (mst_q != tpim_pkg::ST_SEL) |-> mmass_q == '0)
    else $error("mass on rejected event");

  // any status past the count check needs two taus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q && (mst_q != tpim_pkg::ST_FEW) |-> mcnt_out_q >= 8'd2)
    else $error("pair status with fewer than two taus");

  // no beat taken while a mass is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    need_mass |=> !cmd_i.take)
    else $error("input taken during mass computation");

endmodule

`default_nettype wire

@@ sv/tau_pair_invariant_mass.sv @@
// Top level of the tau pair invariant mass block.
// Depends on tpim_pkg, tpim_ctrl and tpim_dp.
//
//   channel   dir   signals                      contents
//   s_axis    in    tvalid/tready/tdata/tuser/tlast  one tau candidate per beat
//   m_axis    out   tvalid/tready/tdata/tuser    one result per event
//   cfg       in    cfg_we_i/cfg_addr_i/cfg_wdata_i  pt_min (0), eta_limit (1)
//
// An event that fails selection gives its result in the cycle after its last beat.
// A selected event runs the 64-step term divider for 24 series terms each of
// sinh and sin after its last beat; no beat is taken meanwhile. While a result
// waits in the output register and the receiver holds off, no beat is taken.
// Reset clears all event state and restores the register defaults.
`default_nettype none

module tau_pair_invariant_mass (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tau_pt[15:0], tau_eta[29:16], tau_phi[42:30], charge[44:43], zeros
  input  wire [tpim_pkg::InDataW-1:0]        s_axis_tdata,
  // tau_valid
  input  wire                                s_axis_tuser,
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // pair_mass[19:0], tau_count[27:20], zeros
  output logic [tpim_pkg::OutDataW-1:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]                         m_axis_tuser,
  input  wire                                cfg_we_i,
  input  wire                                cfg_addr_i,
  input  wire [tpim_pkg::CfgW-1:0]           cfg_wdata_i
);

  tpim_pkg::cmd_t  cmd;
  tpim_pkg::stat_t stat;
  logic [tpim_pkg::MassW-1:0] mass;
  logic [tpim_pkg::CntW-1:0]  count;

  tpim_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tpim_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_tau_i     (s_axis_tuser),
    .in_pt_i      (s_axis_tdata[15:0]),
    .in_eta_i     (s_axis_tdata[29:16]),
    .in_phi_i     (s_axis_tdata[42:30]),
    .in_chg_i     (s_axis_tdata[44:43]),
    .in_last_i    (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_mass_o   (mass),
    .out_count_o  (count)
  );

  assign s_axis_tready = cmd.take;
  assign m_axis_tdata  = {4'd0, count, mass};

endmodule

`default_nettype wire

@@ sim/tb_tau_pair_invariant_mass.sv @@
// Self-checking testbench for tau_pair_invariant_mass: random tau candidate streams,
// an event-level mass predictor and an in-order result check. Depends on tpim_pkg.
`timescale 1ns / 100ps

module tb_tau_pair_invariant_mass;

  typedef struct packed {
    tpim_pkg::status_e               status;
    logic [tpim_pkg::MassW-1:0]      mass;
    logic [tpim_pkg::CntW-1:0]       count;
  } event_res_t;

  // Tracks the top-two candidates per event and predicts one result per event
  class pair_mass_board;
    logic [tpim_pkg::PtW-1:0]  pt_min;
    logic [tpim_pkg::LimW-1:0] eta_limit;
    logic [tpim_pkg::PtW-1:0]  lead_pt, sub_pt;
    int              lead_eta, lead_phi, lead_chg, sub_eta, sub_phi, sub_chg;
    int              n_taus;
    event_res_t      pending_events[$];
    int              errors, seen, selected, saturated;

    function void clear_event();
      lead_pt = '0; sub_pt = '0;
      lead_eta = 0; lead_phi = 0; lead_chg = 0;
      sub_eta = 0; sub_phi = 0; sub_chg = 0;
      n_taus = 0;
    endfunction

    function void reset_regs();
      pt_min = tpim_pkg::PtMinRst;
      eta_limit = tpim_pkg::EtaLimRst;
      errors = 0; seen = 0; selected = 0; saturated = 0;
      clear_event();
    endfunction

    // Q32 Taylor series: sinh when hyp, else |sin| (sum wraps mod 2^64)
    function logic [63:0] half_angle_series(logic [63:0] x, bit hyp);
      logic [127:0] prod;
      logic [63:0]  x2, term, sum, div;
      prod = {64'd0, x} * {64'd0, x};
      x2 = prod[95:32];
      term = x;
      sum = x;
      for (int k = 0; k < tpim_pkg::Terms; k++) begin
        div = 64'((2 * k + 2) * (2 * k + 3));
        prod = {64'd0, term} * {64'd0, x2};
        term = prod[95:32] / div;
        if (hyp || (k % 2 == 1)) sum = sum + term;
        else sum = sum - term;
      end
      if (!hyp && sum[63]) sum = -sum;
      return sum;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [tpim_pkg::MassW-1:0] pair_mass();
      int           de, dp;
      logic [63:0]  sh, sn, xq, r, m;
      logic [127:0] q;
      logic [191:0] x;
      de = lead_eta - sub_eta;
      dp = lead_phi - sub_phi;
      if (de < 0) de = -de;
      if (dp < 0) dp = -dp;
      sh = half_angle_series(64'(de) << 21, 1'b1);
      sn = half_angle_series(64'(dp) << 21, 1'b0);
      q = {64'd0, sh} * {64'd0, sh} + {64'd0, sn} * {64'd0, sn};
      x = {64'd0, q} * {176'd0, lead_pt} * {176'd0, sub_pt};
      if (x >= (192'd1 << 102)) begin
        saturated++;
        return tpim_pkg::MassMax;
      end
      xq = x[103:40];
      r = int_sqrt(xq);
      m = (r + 64'd1024) >> 11;
      if (m > 64'(tpim_pkg::MassMax)) begin
        saturated++;
        return tpim_pkg::MassMax;
      end
      return m[tpim_pkg::MassW-1:0];
    endfunction

    // Accepted input beat: update the ranking, predict on the last beat
    function void note_candidate(bit tau_ok, logic [tpim_pkg::PtW-1:0] pt,
                                 logic [tpim_pkg::EtaW-1:0] eta,
                                 logic [tpim_pkg::PhiW-1:0] phi,
                                 logic [tpim_pkg::ChgW-1:0] chg, bit last);
      event_res_t res;
      int         ae1, ae2;
      if (tau_ok) begin
        if (n_taus == 0) begin
          lead_pt = pt; lead_eta = $signed(eta); lead_phi = $signed(phi);
          lead_chg = $signed(chg);
        end else if (pt > lead_pt) begin
          sub_pt = lead_pt; sub_eta = lead_eta; sub_phi = lead_phi; sub_chg = lead_chg;
          lead_pt = pt; lead_eta = $signed(eta); lead_phi = $signed(phi);
          lead_chg = $signed(chg);
        end else if (n_taus == 1 || pt > sub_pt) begin
          sub_pt = pt; sub_eta = $signed(eta); sub_phi = $signed(phi);
          sub_chg = $signed(chg);
        end
        if (n_taus < int'(tpim_pkg::CountMax)) n_taus++;
      end
      if (!last) return;
      res.mass = '0;
      res.count = tpim_pkg::CntW'(n_taus);
      ae1 = lead_eta < 0 ? -lead_eta : lead_eta;
      ae2 = sub_eta < 0 ? -sub_eta : sub_eta;
      if (n_taus < 2) res.status = tpim_pkg::ST_FEW;
      else if (!((lead_chg == 1 && sub_chg == -1) || (lead_chg == -1 && sub_chg == 1)))
        res.status = tpim_pkg::ST_SIGN;
      else if (lead_pt > pt_min && sub_pt > pt_min &&
               ae1 < int'(eta_limit) && ae2 < int'(eta_limit)) begin
        res.status = tpim_pkg::ST_SEL;
        res.mass = pair_mass();
        selected++;
      end else res.status = tpim_pkg::ST_CUT;
      pending_events.push_back(res);
      clear_event();
    endfunction

    function void check_result(logic [1:0] status, logic [tpim_pkg::MassW-1:0] mass,
                               logic [tpim_pkg::CntW-1:0] count);
      event_res_t want;
      seen++;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d mass %0d count %0d",
                                   status, mass, count);
        return;
      end
      want = pending_events.pop_front();
      if (status !== want.status || mass !== want.mass || count !== want.count) begin
        errors++;
        if (errors <= 10)
          $display("result %0d mismatch: status %0d/%0d mass %0d/%0d count %0d/%0d (exp/act)",
                   seen, want.status, status, want.mass, mass, want.count, count);
      end
    endfunction
  endclass

  logic                              clk_i, rst_ni;
  logic                              s_axis_tvalid, s_axis_tuser, s_axis_tlast;
  logic                              s_axis_tready;
  logic [tpim_pkg::InDataW-1:0]      s_axis_tdata;
  logic                              m_axis_tvalid, m_axis_tready;
  logic [tpim_pkg::OutDataW-1:0]     m_axis_tdata;
  logic [1:0]                        m_axis_tuser;
  logic                              cfg_we_i, cfg_addr_i;
  logic [tpim_pkg::CfgW-1:0]         cfg_wdata_i;

  pair_mass_board board = new();
  int  hold_off;      // receiver stall requested by the stimulus
  int  n_taus_sent;
  longint cycles;

  tau_pair_invariant_mass dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 20000000) begin
      $display("tb_tau_pair_invariant_mass failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random stalls plus requested long hold-offs
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[27:20]);
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(3) == 0) stall = gap_len();
      end
    end
  end

  task automatic send_beat(bit tau_ok, logic [tpim_pkg::PtW-1:0] pt,
                           logic [tpim_pkg::EtaW-1:0] eta, logic [tpim_pkg::PhiW-1:0] phi,
                           logic [tpim_pkg::ChgW-1:0] chg, bit last, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= tau_ok;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {3'd0, chg, phi, eta, pt};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_candidate(tau_ok, pt, eta, phi, chg, last);
    if (tau_ok) n_taus_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [tpim_pkg::CfgW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tpim_pkg::REG_PT_MIN) board.pt_min = val;
    else board.eta_limit = val[tpim_pkg::LimW-1:0];
  endtask

  function automatic logic [tpim_pkg::ChgW-1:0] rand_charge(bit mostly_charged);
    if (mostly_charged && $urandom_range(9) != 0) return $urandom_range(1) ? 2'b01 : 2'b11;
    return tpim_pkg::ChgW'($urandom_range(3));
  endfunction

  // One random event; well-formed ones aim at passing the selection
  task automatic random_event(int n, bit nice, bit gaps);
    logic [tpim_pkg::PtW-1:0]  pt;
    logic [tpim_pkg::EtaW-1:0] eta;
    int              lo, hi, lim;
    for (int i = 0; i < n; i++) begin
      if (nice) begin
        lo = int'(board.pt_min) + 1;
        hi = lo + 3000;
        if (lo > 65535) lo = 65535;
        if (hi > 65535) hi = 65535;
        pt = tpim_pkg::PtW'($urandom_range(hi, lo));
        lim = int'(board.eta_limit) - 1;
        if (lim < 0) lim = 0;
        if ($urandom_range(3) == 0) lim = lim < 200 ? lim : 200;
        eta = tpim_pkg::EtaW'($urandom_range(2 * lim) - lim);
      end else begin
        pt = $urandom_range(3) == 0 ? tpim_pkg::PtW'($urandom_range(65535))
                                    : tpim_pkg::PtW'($urandom_range(900));
        eta = tpim_pkg::EtaW'($urandom());
      end
      // occasionally an item with no tau and junk fields
      if ($urandom_range(15) == 0)
        send_beat(1'b0, tpim_pkg::PtW'($urandom()), tpim_pkg::EtaW'($urandom()),
                  tpim_pkg::PhiW'($urandom()), tpim_pkg::ChgW'($urandom()), 1'b0,
                  gaps ? gap_len() : 0);
      send_beat(1'b1, pt, eta, tpim_pkg::PhiW'($urandom()), rand_charge(nice), i == n - 1,
                gaps ? gap_len() : 0);
    end
    if (n == 0) send_beat(1'b0, tpim_pkg::PtW'($urandom()), tpim_pkg::EtaW'($urandom()),
                          tpim_pkg::PhiW'($urandom()), tpim_pkg::ChgW'($urandom()), 1'b1,
                          gaps ? gap_len() : 0);
  endtask

  task automatic random_phase(int taus);
    int stop, n;
    bit gaps;
    stop = n_taus_sent + taus;
    gaps = 1'b1;
    while (n_taus_sent < stop) begin
      if ($urandom_range(19) == 0) gaps = ~gaps;
      n = $urandom_range(9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 6);
      random_event(n, $urandom_range(9) < 7, gaps);
    end
  endtask

  initial begin
    board.reset_regs();
    hold_off = 0;
    n_taus_sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = tpim_pkg::REG_PT_MIN;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty event, lone tau, no-tau filler mid-event
    send_beat(1'b0, 16'hFFFF, 14'h3FFF, 13'h1FFF, 2'b11, 1'b1, 0);
    send_beat(1'b1, 16'd1000, 14'd0, 13'd0, 2'b01, 1'b1, 0);
    send_beat(1'b1, 16'd500, 14'd100, 13'd200, 2'b01, 1'b0, 0);
    send_beat(1'b0, 16'd9000, 14'd0, 13'd0, 2'b11, 1'b0, 0);
    send_beat(1'b1, 16'd600, -14'sd100, -13'sd200, 2'b11, 1'b1, 0);
    // pt tie: earlier candidate ranks higher, third with equal pt is dropped
    send_beat(1'b1, 16'd800, 14'd10, 13'd4095, 2'b01, 1'b0, 1);
    send_beat(1'b1, 16'd800, 14'd20, -13'sd4096, 2'b11, 1'b0, 0);
    send_beat(1'b1, 16'd800, 14'd30, 13'd0, 2'b01, 1'b1, 0);
    // charge patterns zero and -2 never pair
    send_beat(1'b1, 16'd700, 14'd0, 13'd0, 2'b10, 1'b0, 0);
    send_beat(1'b1, 16'd700, 14'd0, 13'd0, 2'b01, 1'b1, 0);
    send_beat(1'b1, 16'd700, 14'd0, 13'd0, 2'b00, 1'b0, 0);
    send_beat(1'b1, 16'd701, 14'd0, 13'd0, 2'b11, 1'b1, 0);
    // field extremes: full pt, eta limits fail cut
    send_beat(1'b1, 16'hFFFF, 14'h2000, 13'h1000, 2'b01, 1'b0, 0);
    send_beat(1'b1, 16'hFFFE, 14'h1FFF, 13'h0FFF, 2'b11, 1'b1, 0);
    // pt exactly at threshold and eta exactly at limit fail the cut
    send_beat(1'b1, 16'd320, 14'd0, 13'd0, 2'b01, 1'b0, 0);
    send_beat(1'b1, 16'd5000, 14'd2354, 13'd0, 2'b11, 1'b1, 0);
    send_beat(1'b1, 16'd321, 14'd2355, 13'd0, 2'b01, 1'b0, 0);
    send_beat(1'b1, 16'd5000, 14'd0, 13'd0, 2'b11, 1'b1, 0);
    // selected: identical direction, close pair, largest spread
    send_beat(1'b1, 16'd4000, 14'd50, 13'd50, 2'b01, 1'b0, 0);
    send_beat(1'b1, 16'd4000, 14'd50, 13'd50, 2'b11, 1'b1, 0);
    send_beat(1'b1, 16'hFFFF, -14'sd2354, -13'sd4096, 2'b11, 1'b0, 0);
    send_beat(1'b1, 16'hFFFF, 14'd2354, 13'd4095, 2'b01, 1'b1, 0);
    send_beat(1'b1, 16'd321, 14'd1, -13'sd1, 2'b01, 1'b0, 0);
    send_beat(1'b1, 16'd322, 14'd0, 13'd0, 2'b11, 1'b1, 0);

    // Count saturation: one long event
    for (int i = 0; i < 260; i++)
      send_beat(1'b1, tpim_pkg::PtW'($urandom_range(2000)), tpim_pkg::EtaW'($urandom()),
                tpim_pkg::PhiW'($urandom()), rand_charge(1'b1), i == 259, 0);

    random_phase(250);

    // Back-pressure: hold the result side while quick events keep coming
    drain();
    hold_off = 3000;
    for (int i = 0; i < 30; i++) random_event($urandom_range(0, 1), 1'b0, 1'b0);
    drain();

    write_reg(tpim_pkg::REG_PT_MIN, 16'd0);
    write_reg(tpim_pkg::REG_ETA_LIMIT, 16'd8191);
    random_phase(250);
    write_reg(tpim_pkg::REG_PT_MIN, 16'hFFFF);
    write_reg(tpim_pkg::REG_ETA_LIMIT, 16'd0);
    random_phase(150);
    write_reg(tpim_pkg::REG_PT_MIN, tpim_pkg::CfgW'($urandom_range(2000)));
    write_reg(tpim_pkg::REG_ETA_LIMIT, tpim_pkg::CfgW'($urandom_range(8191)));
    random_phase(250);
    write_reg(tpim_pkg::REG_PT_MIN, tpim_pkg::PtMinRst);
    write_reg(tpim_pkg::REG_ETA_LIMIT, 16'(tpim_pkg::EtaLimRst));
    random_phase(150);

    drain();
    repeat (100) @(posedge clk_i);
    $display("%0d taus in %0d events, %0d selected pairs (%0d saturated masses)",
             n_taus_sent, board.seen, board.selected, board.saturated);
    $display("register settings swept: reset, both extremes, random; %0d mismatches",
             board.errors);
    if (board.errors == 0 && board.pending_events.size() == 0)
      $display("tb_tau_pair_invariant_mass passed");
    else
      $display("tb_tau_pair_invariant_mass failed");
    $finish;
  end

endmodule
